FILE: hdl/small_matrix_det_inverse_macros.svh
`ifndef SMALL_MATRIX_DET_INVERSE_MACROS_SVH
`define SMALL_MATRIX_DET_INVERSE_MACROS_SVH

// same-cycle implication
`define SMDI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMDI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/smdi_pkg.sv
package smdi_pkg;

    localparam int DEF_MAX_SIZE   = 4;
    localparam int DEF_ELEM_WIDTH = 16;
    localparam int DIM            = 4;
    localparam int N_PERM         = 24;
    localparam int PERM_W         = 5;
    localparam int IDX_W          = 2;
    localparam int SIZE_W         = 3;
    localparam int FRAC_BITS      = 8;
    localparam int OUT_FRAC       = 16;
    localparam int OUT_W          = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);
    localparam logic [OUT_W-1:0]  SAT_POS    = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0]  SAT_NEG    = 32'h8000_0000;

    // column picked in each row, row k at bits [2k+1:2k], lexicographic order
    localparam logic [7:0] PERM_COLS [N_PERM] = '{
        8'b11_10_01_00, 8'b10_11_01_00, 8'b11_01_10_00, 8'b01_11_10_00,
        8'b10_01_11_00, 8'b01_10_11_00, 8'b11_10_00_01, 8'b10_11_00_01,
        8'b11_00_10_01, 8'b00_11_10_01, 8'b10_00_11_01, 8'b00_10_11_01,
        8'b11_01_00_10, 8'b01_11_00_10, 8'b11_00_01_10, 8'b00_11_01_10,
        8'b01_00_11_10, 8'b00_01_11_10, 8'b10_01_00_11, 8'b01_10_00_11,
        8'b10_00_01_11, 8'b00_10_01_11, 8'b01_00_10_11, 8'b00_01_10_11
    };

    // odd permutations
    localparam logic PERM_ODD [N_PERM] = '{
        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0
    };

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_FIRST, S_MUL_SET, S_MUL, S_ACC, S_DONE, S_DIV, S_EMIT, S_SING
    } t_back_state;

    typedef enum logic {
        KIND_DET = 1'b0,
        KIND_INV = 1'b1
    } t_kind;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [OUT_W-1:0]  value;
        logic              singular;
        logic              saturated;
        logic              last;
    } t_result;

endpackage

FILE: hdl/smdi_queue.sv
module smdi_queue import smdi_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_q_stat      o_stat
);

    logic [W-1:0] r_slot0;
    logic [W-1:0] r_slot1;
    logic [1:0]   r_count;
    logic [1:0]   n_count;
    logic         w_to_slot0;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    assign w_to_slot0 = (r_count == 2'd0) || (r_count == 2'd1 && i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push && w_to_slot0) begin
            r_slot0 <= i_data;
        end else if (i_pop) begin
            r_slot0 <= r_slot1;
        end
        if (i_push && !w_to_slot0) begin
            r_slot1 <= i_data;
        end
    end

    assign o_data       = r_slot0;
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

FILE: hdl/smdi_front.sv
module smdi_front import smdi_pkg::*; #(
    parameter  int MAX_SIZE   = DEF_MAX_SIZE,
    parameter  int ELEM_WIDTH = DEF_ELEM_WIDTH,
    localparam int MW         = MAX_SIZE * MAX_SIZE * ELEM_WIDTH,
    localparam int JW         = MW + SIZE_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [IDX_W-1:0]      i_row_index,
    input  logic [IDX_W-1:0]      i_col_index,
    input  logic [ELEM_WIDTH-1:0] i_elem_value,
    input  logic                  i_load_last,
    input  logic                  i_cfg_valid,
    input  logic [SIZE_W-1:0]     i_cfg_data,
    input  t_q_stat               i_q_stat,
    output logic                  o_push,
    output logic [JW-1:0]         o_job
);

    logic              w_acc;
    logic [MW-1:0]     w_snap;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] w_n;

    assign o_busy = i_q_stat.full;
    assign w_acc  = i_start && !o_busy;
    assign o_push = w_acc && i_load_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    for (genvar a = 0; a < MAX_SIZE; a++) begin : g_row
        for (genvar b = 0; b < MAX_SIZE; b++) begin : g_col
            logic [ELEM_WIDTH-1:0] r_val;
            logic                  w_hit;
            assign w_hit = w_acc && (i_row_index == IDX_W'(a)) && (i_col_index == IDX_W'(b));
            always_ff @(posedge i_clk) begin
                if (w_hit) begin
                    r_val <= i_elem_value;
                end
            end
            // last element joins the snapshot directly
            assign w_snap[(a*MAX_SIZE+b)*ELEM_WIDTH +: ELEM_WIDTH] = w_hit ? i_elem_value : r_val;
        end
    end

    always_comb begin
        if (r_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_SIZE)) begin
            w_n = SIZE_W'(MAX_SIZE);
        end else begin
            w_n = r_size;
        end
    end

    assign o_job = {w_n, w_snap};

endmodule

FILE: hdl/smdi_back.sv
module smdi_back import smdi_pkg::*; #(
    parameter  int MAX_SIZE   = DEF_MAX_SIZE,
    parameter  int ELEM_WIDTH = DEF_ELEM_WIDTH,
    localparam int MW         = MAX_SIZE * MAX_SIZE * ELEM_WIDTH,
    localparam int JW         = MW + SIZE_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [JW-1:0] i_job,
    input  t_q_stat       i_q_stat,
    output logic          o_pop,
    output logic          o_strobe,
    output t_result       o_result
);

    localparam int PW = ELEM_WIDTH + 2;
    localparam int DW = DIM * (ELEM_WIDTH + 1) + 6;
    localparam int NW = DW + OUT_FRAC;
    localparam int BW = $clog2(PW);
    localparam int CW = $clog2(NW);

    t_back_state r_state;
    t_back_state n_state;

    logic [MW-1:0]          r_mat;
    logic [SIZE_W-1:0]      r_n;
    t_kind                  r_kind;
    logic [IDX_W-1:0]       r_i;
    logic [IDX_W-1:0]       r_j;
    logic [PERM_W-1:0]      r_perm;
    logic [IDX_W-1:0]       r_term;
    logic [BW-1:0]          r_bit;
    logic [PW-1:0]          r_mag;
    logic [DW-1:0]          r_prod;
    logic [DW-1:0]          r_mcand;
    logic                   r_psign;
    logic signed [DW-1:0]   r_acc;
    logic [DW-1:0]          r_dmag;
    logic                   r_dneg;
    logic [DW-1:0]          r_rem;
    logic [NW-1:0]          r_quo;
    logic [CW-1:0]          r_dcnt;
    logic                   r_nneg;
    logic                   r_strobe;
    t_result                r_result;

    logic signed [PW-1:0]   w_mat [DIM][DIM];
    logic [IDX_W-1:0]       w_row;
    logic [IDX_W-1:0]       w_col;
    logic                   w_in_blk;
    logic signed [PW-1:0]   w_elem;
    logic [PW-1:0]          w_emag;
    logic                   w_tneg;
    logic [DW-1:0]          w_abs;
    logic [NW-1:0]          w_dext;
    logic [NW-1:0]          w_dscl;
    logic [DW:0]            w_rs;
    logic                   w_ge;
    logic                   w_iend;
    logic                   w_jend;
    logic                   w_emit;
    t_result                w_res;

    function automatic logic [OUT_W:0] f_sat(input logic [NW-1:0] mag, input logic neg);
        logic [OUT_W-1:0] lim;
        logic [OUT_W-1:0] lo;
        lim = neg ? SAT_NEG : SAT_POS;
        lo  = mag[OUT_W-1:0];
        if ((|mag[NW-1:OUT_W]) || lo > lim) begin
            f_sat = {1'b1, lim};
        end else begin
            f_sat = {1'b0, neg ? (~lo + 32'd1) : lo};
        end
    endfunction

    for (genvar a = 0; a < DIM; a++) begin : g_ra
        for (genvar b = 0; b < DIM; b++) begin : g_cb
            if (a < MAX_SIZE && b < MAX_SIZE) begin : g_used
                assign w_mat[a][b] =
                    PW'($signed(r_mat[(a*MAX_SIZE+b)*ELEM_WIDTH +: ELEM_WIDTH]));
            end else begin : g_pad
                assign w_mat[a][b] = '0;
            end
        end
    end

    // element of the current product, padded to 4x4 with identity
    assign w_row    = (r_state == S_FIRST) ? '0 : r_term;
    assign w_col    = PERM_COLS[r_perm][{w_row, 1'b0} +: IDX_W];
    assign w_in_blk = ({1'b0, w_row} < r_n) && ({1'b0, w_col} < r_n);

    always_comb begin
        if (!w_in_blk) begin
            w_elem = (w_row == w_col) ? PW'(1) : '0;
        end else if (r_kind == KIND_INV && w_col == r_i) begin
            w_elem = (w_row == r_j) ? PW'(1 << FRAC_BITS) : '0;
        end else begin
            w_elem = w_mat[w_row][w_col];
        end
    end

    assign w_emag = w_elem[PW-1] ? PW'(-w_elem) : PW'(w_elem);
    assign w_tneg = r_psign ^ PERM_ODD[r_perm];
    assign w_abs  = r_acc[DW-1] ? DW'(-r_acc) : DW'(r_acc);
    assign w_dext = NW'(w_abs);

    always_comb begin
        case (r_n)
            3'd1:    w_dscl = w_dext << FRAC_BITS;
            3'd2:    w_dscl = w_dext;
            3'd3:    w_dscl = w_dext >> FRAC_BITS;
            default: w_dscl = w_dext >> (2 * FRAC_BITS);
        endcase
    end

    assign w_rs   = {r_rem, r_quo[NW-1]};
    assign w_ge   = (w_rs >= {1'b0, r_dmag});
    assign w_iend = ({1'b0, r_i} == r_n - SIZE_W'(1));
    assign w_jend = ({1'b0, r_j} == r_n - SIZE_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (!i_q_stat.empty) n_state = S_START;
            S_START:   n_state = S_FIRST;
            S_FIRST:   n_state = S_MUL_SET;
            S_MUL_SET: n_state = S_MUL;
            S_MUL: begin
                if (r_bit == '0) begin
                    n_state = (r_term == IDX_W'(DIM - 1)) ? S_ACC : S_MUL_SET;
                end
            end
            S_ACC:     n_state = (r_perm == PERM_W'(N_PERM - 1)) ? S_DONE : S_FIRST;
            S_DONE: begin
                if (r_kind == KIND_INV) begin
                    n_state = S_DIV;
                end else if (r_acc == '0) begin
                    n_state = S_SING;
                end else begin
                    n_state = S_START;
                end
            end
            S_DIV:     if (r_dcnt == '0) n_state = S_EMIT;
            S_EMIT:    n_state = (w_iend && w_jend) ? S_IDLE : S_START;
            S_SING:    if (w_iend && w_jend) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        logic [OUT_W:0] sv;
        o_pop     = 1'b0;
        w_emit    = 1'b0;
        w_res     = '0;
        sv        = '0;
        unique case (r_state)
            S_IDLE: o_pop = !i_q_stat.empty;
            S_DONE: begin
                if (r_kind == KIND_DET) begin
                    sv              = f_sat(w_dscl, r_acc[DW-1]);
                    w_emit          = 1'b1;
                    w_res.kind      = KIND_DET;
                    w_res.value     = sv[OUT_W-1:0];
                    w_res.saturated = sv[OUT_W];
                    w_res.singular  = (r_acc == '0);
                end
            end
            S_EMIT: begin
                sv              = f_sat(r_quo, r_nneg ^ r_dneg);
                w_emit          = 1'b1;
                w_res.kind      = KIND_INV;
                w_res.row       = r_i;
                w_res.col       = r_j;
                w_res.value     = sv[OUT_W-1:0];
                w_res.saturated = sv[OUT_W];
                w_res.last      = w_iend && w_jend;
            end
            S_SING: begin
                w_emit         = 1'b1;
                w_res.kind     = KIND_INV;
                w_res.row      = r_i;
                w_res.col      = r_j;
                w_res.singular = 1'b1;
                w_res.last     = w_iend && w_jend;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_result <= w_res;
        end
        case (r_state)
            S_IDLE: begin
                r_mat  <= i_job[MW-1:0];
                r_n    <= i_job[JW-1:MW];
                r_kind <= KIND_DET;
                r_i    <= '0;
                r_j    <= '0;
            end
            S_START: begin
                r_acc  <= '0;
                r_perm <= '0;
            end
            S_FIRST: begin
                r_prod  <= DW'(w_emag);
                r_psign <= w_elem[PW-1];
                r_term  <= IDX_W'(1);
            end
            S_MUL_SET: begin
                r_mcand <= r_prod;
                r_prod  <= '0;
                r_psign <= r_psign ^ w_elem[PW-1];
                r_mag   <= w_emag;
                r_bit   <= BW'(PW - 1);
            end
            S_MUL: begin
                r_prod <= (r_prod << 1) + (r_mag[PW-1] ? r_mcand : '0);
                r_mag  <= r_mag << 1;
                r_bit  <= r_bit - BW'(1);
                if (r_bit == '0) begin
                    r_term <= r_term + IDX_W'(1);
                end
            end
            S_ACC: begin
                r_acc  <= w_tneg ? (r_acc - $signed(r_prod)) : (r_acc + $signed(r_prod));
                r_perm <= r_perm + PERM_W'(1);
            end
            S_DONE: begin
                if (r_kind == KIND_DET) begin
                    r_dmag <= w_abs;
                    r_dneg <= r_acc[DW-1];
                    r_kind <= KIND_INV;
                end else begin
                    r_rem  <= '0;
                    r_quo  <= {w_abs, {OUT_FRAC{1'b0}}};
                    r_nneg <= r_acc[DW-1];
                    r_dcnt <= CW'(NW - 1);
                end
            end
            S_DIV: begin
                r_rem  <= w_ge ? DW'(w_rs - {1'b0, r_dmag}) : w_rs[DW-1:0];
                r_quo  <= {r_quo[NW-2:0], w_ge};
                r_dcnt <= r_dcnt - CW'(1);
            end
            S_EMIT, S_SING: begin
                if (w_jend) begin
                    r_j <= '0;
                    r_i <= r_i + IDX_W'(1);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: hdl/small_matrix_det_inverse.sv
// Determinant and Cramer-rule inverse of an N by N matrix (N = 1..4, signed Q8.8 elements).
// Elements load one per cycle while busy is low; the transfer flagged load_last starts a run
// that emits the determinant and then the N*N inverse entries in row-major order, one per
// o_result_strobe pulse. Results cannot be held off: take each on the cycle its strobe is
// high. Loaded matrices are snapshotted into a two-entry job queue, so a new matrix can load
// while the previous run computes; busy rises only when both entries are taken. Each
// determinant is a sum over 24 permutations, each formed by three bit-serial multiplies;
// each inverse entry also runs a restoring divider. A smaller N does not shorten the
// determinant loop. A zero determinant flags singular and its inverse entries stream out
// as zeros, one per cycle.
`include "small_matrix_det_inverse_macros.svh"

module small_matrix_det_inverse import smdi_pkg::*; #(
    parameter int MAX_SIZE   = DEF_MAX_SIZE,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [IDX_W-1:0]      i_row_index,
    input  logic [IDX_W-1:0]      i_col_index,
    input  logic [ELEM_WIDTH-1:0] i_elem_value,
    input  logic                  i_load_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SIZE_W-1:0]     i_cfg_data,
    output logic                  o_result_strobe,
    output logic                  o_result_kind,
    output logic [IDX_W-1:0]      o_out_row,
    output logic [IDX_W-1:0]      o_out_col,
    output logic [OUT_W-1:0]      o_out_value,
    output logic                  o_singular,
    output logic                  o_saturated,
    output logic                  o_run_last
);

    localparam int JW = MAX_SIZE * MAX_SIZE * ELEM_WIDTH + SIZE_W;

    logic          w_push;
    logic          w_pop;
    logic [JW-1:0] w_job_in;
    logic [JW-1:0] w_job_out;
    t_q_stat       w_q_stat;
    t_result       w_result;

    assign o_cfg_ready = 1'b1;

    smdi_front #(
        .MAX_SIZE   (MAX_SIZE),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_elem_value (i_elem_value),
        .i_load_last  (i_load_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_job        (w_job_in)
    );

    smdi_queue #(
        .W (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_stat  (w_q_stat)
    );

    smdi_back #(
        .MAX_SIZE   (MAX_SIZE),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_job_out),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_strobe (o_result_strobe),
        .o_result (w_result)
    );

    assign o_result_kind = w_result.kind;
    assign o_out_row     = w_result.row;
    assign o_out_col     = w_result.col;
    assign o_out_value   = w_result.value;
    assign o_singular    = w_result.singular;
    assign o_saturated   = w_result.saturated;
    assign o_run_last    = w_result.last;

    `SMDI_ASSERT_IMP(a_det_not_last, i_clk, i_rst_n,
        o_result_strobe && o_result_kind == KIND_DET, !o_run_last, "determinant marked last")
    `SMDI_ASSERT_IMP(a_det_pos, i_clk, i_rst_n,
        o_result_strobe && o_result_kind == KIND_DET, o_out_row == '0 && o_out_col == '0,
        "determinant with nonzero position")
    `SMDI_ASSERT_IMP(a_sing_zero, i_clk, i_rst_n,
        o_result_strobe && o_singular, o_out_value == '0 && !o_saturated,
        "singular result not zero")
    `SMDI_ASSERT_NXT(a_push_lands, i_clk, i_rst_n,
        w_push && w_q_stat.empty && !w_pop, !w_q_stat.empty, "queued job lost")

endmodule
